FILE: hw/rtl/lifo_stack_indexed_access_defines.svh
// Assertion macros shared by the stack RTL
`ifndef LIFO_STACK_INDEXED_ACCESS_DEFINES_SVH
`define LIFO_STACK_INDEXED_ACCESS_DEFINES_SVH

// Check that cons holds in the same cycle as ante
`define LSIA_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// Check that cons holds in the cycle after ante
`define LSIA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hw/rtl/lsia_pkg.sv
// Types and constants for the indexed-access stack
package lsia_pkg;
	localparam int STACK_DEPTH = 64;
	localparam int WORD_W      = 32;
	localparam int POS_W       = 6;
	localparam int FUNC_W      = 2;
	localparam int STAT_W      = 2;
	localparam int OCC_W       = 7;
	localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
	localparam int CMP_W       = (CNT_W > POS_W) ? CNT_W : POS_W;
	localparam int IN_DATA_W   = 40;
	localparam int OUT_DATA_W  = 40;

	typedef enum logic [FUNC_W-1:0] {
		OP_PUSH   = 2'd0,
		OP_POP    = 2'd1,
		OP_PEEK   = 2'd2,
		OP_CHANGE = 2'd3
	} op_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK        = 2'd0,
		ST_OVERFLOW  = 2'd1,
		ST_UNDERFLOW = 2'd2,
		ST_RANGE     = 2'd3
	} status_t;

	// Per-cycle command broadcast along the cell row
	typedef struct packed {
		logic push;
		logic pop;
		logic change;
	} cell_ctl_t;
endpackage

FILE: hw/rtl/lsia_cell.sv
// One stack entry: shifts with push and pop, loads on a matching change
module lsia_cell (
	input  logic                          clk,
	input  lsia_pkg::cell_ctl_t           ctl,
	input  logic                          sel,
	input  logic [lsia_pkg::WORD_W-1:0]   value,
	input  logic [lsia_pkg::WORD_W-1:0]   upper_word,
	input  logic [lsia_pkg::WORD_W-1:0]   lower_word,
	output logic [lsia_pkg::WORD_W-1:0]   word,
	output logic [lsia_pkg::WORD_W-1:0]   tap
);
	import lsia_pkg::*;

	logic [WORD_W-1:0] word_q;

	// Push moves entries away from the top, pop moves them toward it
	always_ff @(posedge clk) begin
		if (ctl.push) begin
			word_q <= upper_word;
		end else if (ctl.pop) begin
			word_q <= lower_word;
		end else if (ctl.change && sel) begin
			word_q <= value;
		end
	end

	assign word = word_q;
	assign tap  = sel ? word_q : '0;
endmodule

FILE: hw/rtl/lifo_stack_indexed_access.sv
// Bounded stack of 32-bit words with push, pop, peek and change at a depth
// from the top. The store is a row of STACK_DEPTH cells, cell 0 holding the
// top; push and pop shift the whole row by one position, peek and
// change pick the cell whose depth matches position. One request is taken
// per clock; its result appears in the output register on the next cycle,
// and a new request is taken whenever that register is empty or is being
// drained in the same cycle, so throughput is one request per cycle while
// the downstream side keeps tready high. Entries are not cleared at reset;
// only words below the occupancy are ever read.
`include "lifo_stack_indexed_access_defines.svh"

module lifo_stack_indexed_access (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	// value [31:0], position [37:32], zero fill
	input  logic [lsia_pkg::IN_DATA_W-1:0]     s_axis_tdata,
	// func [1:0]
	input  logic [lsia_pkg::FUNC_W-1:0]        s_axis_tuser,
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	// read_word [31:0], occupancy [38:32], zero fill
	output logic [lsia_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
	// status [1:0]
	output logic [lsia_pkg::STAT_W-1:0]        m_axis_tuser
);
	import lsia_pkg::*;

	logic                accept;
	op_t                 op;
	logic [WORD_W-1:0]   value;
	logic [POS_W-1:0]    position;
	logic                empty;
	logic                full;

	logic [CNT_W-1:0]    cnt_q;
	logic [CNT_W-1:0]    cnt_nx;
	cell_ctl_t           cmd;
	cell_ctl_t           ctl;
	status_t             st_nx;
	logic [WORD_W-1:0]   rd_nx;

	logic                out_vld_q;
	logic [WORD_W-1:0]   rd_q;
	status_t             st_q;
	logic [CNT_W-1:0]    occ_q;

	logic [WORD_W-1:0]   cell_word [STACK_DEPTH];
	logic [WORD_W-1:0]   cell_tap  [STACK_DEPTH];
	logic [STACK_DEPTH-1:0] cell_sel;
	logic [WORD_W-1:0]   peek_word;

	assign s_axis_tready = !out_vld_q || m_axis_tready;
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign op            = op_t'(s_axis_tuser);
	assign value         = s_axis_tdata[WORD_W-1:0];
	assign position      = s_axis_tdata[WORD_W+POS_W-1:WORD_W];
	assign empty         = (cnt_q == '0);
	assign full          = (cnt_q == CNT_W'(STACK_DEPTH));

	// Cell row, top of stack at index 0
	for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
		logic [WORD_W-1:0] upper;
		logic [WORD_W-1:0] lower;

		assign cell_sel[i] = (CMP_W'(position) == CMP_W'(i));

		if (i == 0) begin : g_top
			assign upper = value;
		end else begin : g_mid
			assign upper = cell_word[i-1];
		end
		if (i == STACK_DEPTH - 1) begin : g_bot
			assign lower = '0;
		end else begin : g_low
			assign lower = cell_word[i+1];
		end

		lsia_cell u_cell (
			.clk        (clk),
			.ctl        (ctl),
			.sel        (cell_sel[i]),
			.value      (value),
			.upper_word (upper),
			.lower_word (lower),
			.word       (cell_word[i]),
			.tap        (cell_tap[i])
		);
	end

	// Only one cell drives a nonzero tap, so OR them together
	always_comb begin
		peek_word = '0;
		for (int i = 0; i < STACK_DEPTH; i++) begin
			peek_word = peek_word | cell_tap[i];
		end
	end

	always_comb begin
		cmd    = '0;
		st_nx  = ST_OK;
		rd_nx  = '0;
		cnt_nx = cnt_q;
		case (op)
			OP_PUSH: begin
				if (full) begin
					st_nx = ST_OVERFLOW;
				end else begin
					cmd.push = 1'b1;
					cnt_nx   = cnt_q + CNT_W'(1);
				end
			end
			OP_POP: begin
				if (empty) begin
					st_nx = ST_UNDERFLOW;
				end else begin
					cmd.pop = 1'b1;
					rd_nx   = cell_word[0];
					cnt_nx  = cnt_q - CNT_W'(1);
				end
			end
			OP_PEEK, OP_CHANGE: begin
				if (empty) begin
					st_nx = ST_UNDERFLOW;
				end else if (CMP_W'(position) >= CMP_W'(cnt_q)) begin
					st_nx = ST_RANGE;
				end else if (op == OP_PEEK) begin
					rd_nx = peek_word;
				end else begin
					cmd.change = 1'b1;
				end
			end
			default: begin
				st_nx = ST_OK;
			end
		endcase
	end

	// Drop the command unless the request is taken this cycle
	assign ctl = accept ? cmd : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q     <= '0;
			out_vld_q <= 1'b0;
		end else begin
			if (accept) begin
				cnt_q <= cnt_nx;
			end
			if (accept) begin
				out_vld_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rd_q  <= rd_nx;
			st_q  <= st_nx;
			occ_q <= cnt_nx;
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = {{(OUT_DATA_W-WORD_W-OCC_W){1'b0}}, OCC_W'(occ_q), rd_q};
	assign m_axis_tuser  = st_q;

	`LSIA_ASSERT_NEXT(a_full_push, accept && op == OP_PUSH && full, m_axis_tuser == ST_OVERFLOW && cnt_q == $past(cnt_q), "push on full stack did not report overflow")
	`LSIA_ASSERT_NEXT(a_pop_top, accept && op == OP_POP && !empty, m_axis_tdata[WORD_W-1:0] == $past(cell_word[0]) && cnt_q == $past(cnt_q) - CNT_W'(1), "pop did not return the top word")
	`LSIA_ASSERT_SAME(a_hold_out, out_vld_q && !m_axis_tready, !s_axis_tready && !accept, "request taken while result is stalled")
	`LSIA_ASSERT_SAME(a_occ_bound, out_vld_q, occ_q <= CNT_W'(STACK_DEPTH), "occupancy beyond stack depth")
endmodule

FILE: tb/tb.sv
// Self-checking testbench for the indexed-access stack: scoreboard class plus stream drivers
`timescale 1ns / 100ps

module tb;
	import lsia_pkg::*;

	localparam int IDLE_LIMIT = 1000;
	localparam int SEG_ITEMS  = 190;
	localparam int SEG_COUNT  = 8;

	typedef enum int {
		MODE_FILL,
		MODE_DRAIN,
		MODE_MIXED
	} traffic_mode_t;

	typedef struct packed {
		logic [WORD_W-1:0] read_word;
		status_t           status;
		logic [OCC_W-1:0]  occupancy;
	} stack_result_t;

	// Tracks the stack contents and the results still owed by the block
	class stack_scoreboard;
		logic [WORD_W-1:0] words[STACK_DEPTH];
		logic [OCC_W-1:0]  held;
		stack_result_t     owed[$];
		int                errors;

		function new();
			held   = '0;
			errors = 0;
		endfunction

		function void note_request(op_t op, logic [WORD_W-1:0] value, logic [POS_W-1:0] pos);
			stack_result_t    r;
			logic [POS_W-1:0] slot;
			r.read_word = '0;
			r.status    = ST_OK;
			case (op)
				OP_PUSH: begin
					if (held >= STACK_DEPTH) begin
						r.status = ST_OVERFLOW;
					end else begin
						words[held[POS_W-1:0]] = value;
						held++;
					end
				end
				OP_POP: begin
					if (held == 0) begin
						r.status = ST_UNDERFLOW;
					end else begin
						held--;
						r.read_word = words[held[POS_W-1:0]];
					end
				end
				default: begin
					if (held == 0) begin
						r.status = ST_UNDERFLOW;
					end else if ({1'b0, pos} >= held) begin
						r.status = ST_RANGE;
					end else begin
						slot = POS_W'(held - {1'b0, pos} - OCC_W'(1));
						if (op == OP_PEEK)
							r.read_word = words[slot];
						else
							words[slot] = value;
					end
				end
			endcase
			r.occupancy = held;
			owed.push_back(r);
		endfunction

		task report_mismatch(string what, logic [WORD_W-1:0] got, logic [WORD_W-1:0] want);
			errors++;
			$display("%0t: %s mismatch: got %h expected %h", $time, what, got, want);
		endtask

		task check_result(logic [OUT_DATA_W-1:0] data, logic [STAT_W-1:0] user);
			stack_result_t want;
			if (owed.size() == 0) begin
				report_mismatch("unexpected result", data[WORD_W-1:0], '0);
			end else begin
				want = owed.pop_front();
				if (data[WORD_W-1:0] !== want.read_word)
					report_mismatch("read_word", data[WORD_W-1:0], want.read_word);
				if (user !== want.status)
					report_mismatch("status", user, want.status);
				if (data[WORD_W+OCC_W-1:WORD_W] !== want.occupancy)
					report_mismatch("occupancy", data[WORD_W+OCC_W-1:WORD_W], want.occupancy);
			end
		endtask
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata = '0;
	logic [FUNC_W-1:0]     s_tuser = '0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic [STAT_W-1:0]     m_tuser;

	stack_scoreboard sb = new();
	bit              idling = 1'b1;
	int              quiet_cycles = 0;

	always #2 clk = ~clk;

	lifo_stack_indexed_access u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_tvalid),
		.s_axis_tready (s_tready),
		.s_axis_tdata  (s_tdata),
		.s_axis_tuser  (s_tuser),
		.m_axis_tvalid (m_tvalid),
		.m_axis_tready (m_tready),
		.m_axis_tdata  (m_tdata),
		.m_axis_tuser  (m_tuser)
	);

	// Offer one request, possibly after an idle burst, and hold it until taken
	task send_request(op_t op, logic [WORD_W-1:0] value, logic [POS_W-1:0] pos);
		if (idling && $urandom_range(0, 5) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {{(IN_DATA_W-WORD_W-POS_W){1'b0}}, pos, value};
		s_tuser  <= op;
		do
			@(posedge clk);
		while (!s_tready);
		sb.note_request(op, value, pos);
	endtask

	function automatic logic [WORD_W-1:0] pick_word();
		case ($urandom_range(0, 9))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return 32'h0000_0000;
			3: return 32'hffff_ffff;
			default: return $urandom;
		endcase
	endfunction

	function automatic op_t pick_op(traffic_mode_t mode);
		int r;
		r = $urandom_range(0, 99);
		case (mode)
			MODE_FILL:  return (r < 60) ? OP_PUSH : (r < 70) ? OP_POP :
				(r < 85) ? OP_PEEK : OP_CHANGE;
			MODE_DRAIN: return (r < 10) ? OP_PUSH : (r < 60) ? OP_POP :
				(r < 80) ? OP_PEEK : OP_CHANGE;
			default:    return op_t'(FUNC_W'(r % 4));
		endcase
	endfunction

	// Mostly in-range depths, with the boundary and the whole field mixed in
	function automatic logic [POS_W-1:0] pick_pos(logic [OCC_W-1:0] held);
		int r;
		r = $urandom_range(0, 9);
		if (held != 0 && r < 7)
			return POS_W'($urandom_range(0, int'(held) - 1));
		if (held != 0 && held < STACK_DEPTH && r == 7)
			return held[POS_W-1:0];
		return POS_W'($urandom_range(0, STACK_DEPTH - 1));
	endfunction

	// Result side: sample the handshake, then pick the next ready with stall bursts
	initial begin : result_sink
		int stall_left;
		stall_left = 0;
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready)
				sb.check_result(m_tdata, m_tuser);
			if (stall_left > 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else if (idling && $urandom_range(0, 5) == 0) begin
				stall_left = $urandom_range(1, 7) - 1;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// Stop the run if neither side moves for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= IDLE_LIMIT) begin
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
		end
	end

	initial begin : stimulus
		traffic_mode_t mode;
		op_t           op;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty stack: pop, peek and change underflow
		send_request(OP_POP, 32'h1234_5678, 6'd0);
		send_request(OP_PEEK, 32'h0, 6'd0);
		send_request(OP_CHANGE, 32'hdead_beef, 6'd5);
		send_request(OP_PUSH, 32'h7fff_ffff, 6'd63);
		send_request(OP_PUSH, 32'h8000_0000, 6'd0);
		send_request(OP_PUSH, 32'h0000_0000, 6'd0);
		send_request(OP_PUSH, 32'hffff_ffff, 6'd0);
		send_request(OP_PEEK, 32'h0, 6'd0);
		send_request(OP_PEEK, 32'h0, 6'd3);
		// Depth at and past the held words
		send_request(OP_PEEK, 32'h0, 6'd4);
		send_request(OP_PEEK, 32'h0, 6'd63);
		send_request(OP_CHANGE, 32'h5555_aaaa, 6'd1);
		send_request(OP_PEEK, 32'h0, 6'd1);
		send_request(OP_CHANGE, 32'haaaa_5555, 6'd3);
		send_request(OP_PEEK, 32'h0, 6'd3);
		send_request(OP_CHANGE, 32'h0bad_f00d, 6'd4);
		send_request(OP_CHANGE, 32'hffff_ffff, 6'd0);
		repeat (4) send_request(OP_POP, 32'h0, 6'd0);
		send_request(OP_POP, 32'h0, 6'd0);

		for (int seg = 0; seg < SEG_COUNT; seg++) begin
			case (seg % 4)
				0, 2:    mode = MODE_FILL;
				1:       mode = MODE_DRAIN;
				default: mode = MODE_MIXED;
			endcase
			if (seg == SEG_COUNT - 1)
				idling = 1'b0;
			for (int i = 0; i < SEG_ITEMS; i++) begin
				op = pick_op(mode);
				send_request(op, pick_word(), pick_pos(sb.held));
			end
		end
		s_tvalid <= 1'b0;

		while (sb.owed.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (sb.errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end
endmodule
